@@ design/cascaded_biquad_iir_filter_top_assert.svh @@
// Assertion macros shared by the checker of the biquad filter block.
`ifndef CASCADED_BIQUAD_IIR_FILTER_TOP_ASSERT_SVH
`define CASCADED_BIQUAD_IIR_FILTER_TOP_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define CBQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CBQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/cbq_pkg.sv @@
// Types and constants of the cascaded biquad filter.
`timescale 1ns / 1ps
package cbq_pkg;
    localparam int SAMPLE_W = 12;
    localparam int HIST_W   = 32;
    localparam int COEF_W   = 21;
    localparam int ACC_W    = 56;
    localparam int FRAC_SH  = 18;

    localparam logic [1:0] SEL_BYPASS  = 2'd0;
    localparam logic [1:0] SEL_NOTCH   = 2'd1;
    localparam logic [1:0] SEL_LOWPASS = 2'd2;

    typedef logic signed [COEF_W-1:0] coef_t;

    // Coefficient k (0 b0, 1 b1, 2 b2, 3 a1, 4 a2) of a section for a mode.
    function automatic coef_t coef_lookup(input logic [1:0] sel, input logic [1:0] sect,
                                          input logic [2:0] k);
        coef_t c;
        c = (k == 3'd0) ? coef_t'(262144) : coef_t'(0);
        if (sel == SEL_NOTCH && sect == 2'd0) begin
            case (k)
                3'd0: c = coef_t'(252990);
                3'd1: c = coef_t'(-368960);
                3'd2: c = coef_t'(252990);
                3'd3: c = coef_t'(-369126);
                3'd4: c = coef_t'(252820);
                default: c = coef_t'(0);
            endcase
        end else if (sel == SEL_NOTCH && sect == 2'd1) begin
            case (k)
                3'd0: c = coef_t'(262144);
                3'd1: c = coef_t'(-382310);
                3'd2: c = coef_t'(262144);
                3'd3: c = coef_t'(-381911);
                3'd4: c = coef_t'(253161);
                default: c = coef_t'(0);
            endcase
        end else if (sel == SEL_LOWPASS && sect == 2'd0) begin
            case (k)
                3'd0: c = coef_t'(1265);
                3'd1: c = coef_t'(2529);
                3'd2: c = coef_t'(1265);
                3'd3: c = coef_t'(-274884);
                3'd4: c = coef_t'(77631);
                default: c = coef_t'(0);
            endcase
        end else if (sel == SEL_LOWPASS && sect == 2'd1) begin
            case (k)
                3'd0: c = coef_t'(262144);
                3'd1: c = coef_t'(524288);
                3'd2: c = coef_t'(262144);
                3'd3: c = coef_t'(-346270);
                3'd4: c = coef_t'(165869);
                default: c = coef_t'(0);
            endcase
        end
        return c;
    endfunction
endpackage

@@ design/cbq_mac.sv @@
// Bit-serial multiply-accumulate: one multiplier bit per cycle.
`timescale 1ns / 1ps
module cbq_mac
    import cbq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     start,
    input  logic                     clear,
    input  logic                     subtract,
    input  logic signed [HIST_W-1:0] operand,
    input  coef_t                    coef,
    output logic                     busy,
    output logic signed [ACC_W-1:0]  acc
);
    localparam int CNT_W = $clog2(COEF_W + 1);

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] mcand_reg, mcand_next;
    logic [COEF_W-1:0]       mplier_reg, mplier_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    neg_reg, neg_next;

    // Shift-and-add over the coefficient bits; the top bit carries negative weight.
    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        if (start) begin
            mcand_next  = ACC_W'(operand);
            mplier_next = coef;
            cnt_next    = CNT_W'(COEF_W);
            neg_next    = subtract;
            if (clear) begin
                acc_next = '0;
            end
        end else if (cnt_reg != '0) begin
            if (mplier_reg[0]) begin
                if ((cnt_reg == CNT_W'(1)) != neg_reg) begin
                    acc_next = acc_reg - mcand_reg;
                end else begin
                    acc_next = acc_reg + mcand_reg;
                end
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
    end

    assign busy = (cnt_reg != '0) || start;
    assign acc  = acc_reg;
endmodule

@@ design/cascaded_biquad_iir_filter_top.sv @@
// Top level of the cascaded biquad filter for 12-bit converter samples.
// Usage: samples enter on the s_axis group, tdata = {raw_sample, channel}.
// Results leave on the m_axis group, tdata = {dac_level, filtered_sample, out_channel}.
// filter_select is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Each section takes five products, each formed bit-serially over 21 coefficient
// bits in the shared multiply-accumulate unit: a load state, the shift steps and a
// state to see the unit finish, and the section ends with a history update state.
// Bypass and out-of-range channels go straight from the idle to the done state.
// One transaction is worked on at a time; s_axis_tready is low meanwhile.
// The result waits in an output register while m_axis_tready is low; a further
// transaction may be accepted meanwhile, and once it is finished the sequencer
// holds it until that register is taken.
// Reset clears all history to zero and sets filter_select to the notch.
// History lives in flip-flop arrays, cleared at once by reset.
// No clearing pass is needed.
// The multiplier unit sets the rate.
`timescale 1ns / 1ps
module cascaded_biquad_iir_filter_top
    import cbq_pkg::*;
#(
    parameter int CHANNELS = 2,
    parameter int SECTIONS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // channel [0], raw_sample [12:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // out_channel [0], filtered_sample [12:1], dac_level [20:13]
);
    localparam int NSLOT = CHANNELS * SECTIONS;
    localparam int SL_W  = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int SC_W  = 2;

    typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_MUL, ST_SEC, ST_DONE} state_t;

    state_t                   state_reg;
    logic [1:0]               sel_reg;
    logic                     ch_reg;
    logic [SAMPLE_W-1:0]      raw_reg;
    logic                     bypass_reg;
    logic [SC_W-1:0]          sect_reg;
    logic [2:0]               term_reg;
    logic signed [HIST_W-1:0] x_reg;
    logic signed [HIST_W-1:0] x1_mem [NSLOT];
    logic signed [HIST_W-1:0] x2_mem [NSLOT];
    logic signed [HIST_W-1:0] y1_mem [NSLOT];
    logic signed [HIST_W-1:0] y2_mem [NSLOT];
    logic                     ovalid_reg;
    logic [23:0]              odata_reg;

    logic                     mac_start;
    logic                     mac_busy;
    logic signed [ACC_W-1:0]  mac_acc;
    logic signed [HIST_W-1:0] operand;
    logic [SL_W-1:0]          slot;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [HIST_W-1:0] y_sat;
    logic [SAMPLE_W-1:0]      clamp;
    logic [SAMPLE_W-1:0]      result;
    logic                     filt_on;

    assign slot = SL_W'(32'(ch_reg) * SECTIONS + 32'(sect_reg));
    assign filt_on = (sel_reg == SEL_NOTCH || sel_reg == SEL_LOWPASS)
                     && (32'(s_axis_tdata[0]) < CHANNELS);

    // Operand for the current product term.
    always_comb begin
        case (term_reg)
            3'd0:    operand = x_reg;
            3'd1:    operand = x1_mem[slot];
            3'd2:    operand = x2_mem[slot];
            3'd3:    operand = y1_mem[slot];
            default: operand = y2_mem[slot];
        endcase
    end

    assign mac_start = (state_reg == ST_LOAD);

    cbq_mac u_mac (
        .aclk     (aclk),
        .start    (mac_start),
        .clear    (term_reg == 3'd0),
        .subtract (term_reg >= 3'd3),
        .operand  (operand),
        .coef     (coef_lookup(sel_reg, sect_reg, term_reg)),
        .busy     (mac_busy),
        .acc      (mac_acc)
    );

    // Floor by 2^18 and saturate to 32 bits; then floor by 2^12 and clamp.
    always_comb begin
        shifted = mac_acc >>> FRAC_SH;
        if (shifted > ACC_W'(64'sh7FFFFFFF)) begin
            y_sat = 32'sh7FFFFFFF;
        end else if (shifted < -ACC_W'(64'sh80000000)) begin
            y_sat = -32'sh7FFFFFFF - 32'sd1;
        end else begin
            y_sat = shifted[HIST_W-1:0];
        end
        if (x_reg[HIST_W-1]) begin
            clamp = '0;
        end else if (x_reg[HIST_W-2:24] != '0) begin
            clamp = '1;
        end else begin
            clamp = x_reg[23:12];
        end
    end

    // Sequencer, configuration register, history arrays and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sel_reg    <= SEL_NOTCH;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < NSLOT; i++) begin
                x1_mem[i] <= '0;
                x2_mem[i] <= '0;
                y1_mem[i] <= '0;
                y2_mem[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                sel_reg <= cfg_wr_data;
            end
            if (m_axis_tvalid && m_axis_tready && state_reg != ST_DONE) begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        ch_reg     <= s_axis_tdata[0];
                        raw_reg    <= s_axis_tdata[12:1];
                        x_reg      <= {8'd0, s_axis_tdata[12:1], 12'd0};
                        bypass_reg <= !filt_on;
                        sect_reg   <= '0;
                        term_reg   <= '0;
                        state_reg  <= filt_on ? ST_LOAD : ST_DONE;
                    end
                end
                ST_LOAD: state_reg <= ST_MUL;
                ST_MUL: begin
                    if (!mac_busy) begin
                        if (term_reg == 3'd4) begin
                            state_reg <= ST_SEC;
                        end else begin
                            term_reg  <= term_reg + 3'd1;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_SEC: begin
                    x2_mem[slot] <= x1_mem[slot];
                    x1_mem[slot] <= x_reg;
                    y2_mem[slot] <= y1_mem[slot];
                    y1_mem[slot] <= y_sat;
                    x_reg        <= y_sat;
                    term_reg     <= '0;
                    if (32'(sect_reg) == SECTIONS - 1) begin
                        state_reg <= ST_DONE;
                    end else begin
                        sect_reg  <= sect_reg + SC_W'(1);
                        state_reg <= ST_LOAD;
                    end
                end
                ST_DONE: begin
                    if (!ovalid_reg || m_axis_tready) begin
                        ovalid_reg <= 1'b1;
                        odata_reg  <= {3'd0, result[11:4], result, ch_reg};
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // A sample marked for bypass passes unfiltered.
    assign result = bypass_reg ? raw_reg : clamp;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
endmodule

@@ design/cbq_checker.sv @@
// Port-level checker for the biquad filter block and its bind.
`timescale 1ns / 1ps
`include "cascaded_biquad_iir_filter_top_assert.svh"
module cbq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    // A stalled result holds its value.
    `CBQ_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // The DAC level is the top eight bits of the filtered sample.
    `CBQ_ASSERT_IMP(a_dac, aclk, aresetn, m_axis_tvalid, m_axis_tdata[20:13] == m_axis_tdata[12:5])
    // After an accepted transaction no other is accepted in the next cycle.
    `CBQ_ASSERT_NEXT(a_one, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // Padding bits stay zero.
    `CBQ_ASSERT_IMP(a_pad, aclk, aresetn, m_axis_tvalid, m_axis_tdata[23:21] == 3'd0)
endmodule

bind cascaded_biquad_iir_filter_top cbq_checker u_cbq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
